// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the segment intersection core.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/sid_pkg.sv =====
// Package of the segment intersection core: widths and reset constants.
// Depends on nothing.
`default_nettype none
package sid_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int DIST_BITS = 33;
  localparam int Q_BITS = 34;
  localparam logic [DIST_BITS-1:0] NO_HIT_RESET = 33'd6553600000;
endpackage
`default_nettype wire

// ===== rtl/sid_div_cell.sv =====
// One restoring division cell: a quotient bit per cycle while enabled, passing its item on.
// Depends on sid_pkg.
`default_nettype none
module sid_div_cell #(
  parameter int DW = 34,
  parameter int PW = 100
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [DW-1:0]                rem_in,
  input  wire logic [DW-1:0]                den_in,
  input  wire logic [sid_pkg::Q_BITS-1:0]   q_in,
  input  wire logic [PW-1:0]                pay_in,
  output logic      [DW-1:0]                rem_out,
  output logic      [DW-1:0]                den_out,
  output logic      [sid_pkg::Q_BITS-1:0]   q_out,
  output logic      [PW-1:0]                pay_out
);
  import sid_pkg::*;
  localparam int Q_W = Q_BITS;
  logic [DW:0] sh;
  logic [DW:0] df;
  always_comb begin
    sh = {rem_in, 1'b0};
    df = sh - {1'b0, den_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      pay_out <= pay_in;
      if (!df[DW]) begin
        rem_out <= df[DW-1:0];
        q_out   <= {q_in[Q_W-2:0], 1'b1};
      end else begin
        rem_out <= sh[DW-1:0];
        q_out   <= {q_in[Q_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/segment_intersection_distance_core.sv =====
// Latency is 41 register stages; one item per cycle while the output is not
// stalled.
// The 32 division cells of the r ratio chain set most of the latency.
// A stalled output stalls the whole chain; the input is ready when the
// output register is empty or being taken.
// Synchronous reset clears the valid bits and loads the no-hit reset value.
`default_nettype none
module segment_intersection_distance_core #(
  parameter int COORD_BITS = sid_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sid_pkg::DIST_BITS-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  a_start_x,
  input  wire logic signed [COORD_BITS-1:0]  a_start_y,
  input  wire logic signed [COORD_BITS-1:0]  a_end_x,
  input  wire logic signed [COORD_BITS-1:0]  a_end_y,
  input  wire logic signed [COORD_BITS-1:0]  b_start_x,
  input  wire logic signed [COORD_BITS-1:0]  b_start_y,
  input  wire logic signed [COORD_BITS-1:0]  b_end_x,
  input  wire logic signed [COORD_BITS-1:0]  b_end_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               segments_meet,
  output logic                               crossing_found,
  output logic [sid_pkg::DIST_BITS-1:0]      distance_squared
);
  import sid_pkg::*;
  `include "assert_macros.svh"

  localparam int DB = COORD_BITS + 1;
  localparam int PB = 2 * DB + 1;
  localparam int NCELL = 32;
  localparam int LAT = NCELL + 9;
  localparam int PAYW = PB + 3;
  localparam int MW = (PB + Q_BITS + 1 > DIST_BITS + 33) ? PB + Q_BITS + 1 : DIST_BITS + 33;

  logic [DIST_BITS-1:0] no_hit;
  logic [LAT-2:0] vld;
  logic adv;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_hit <= NO_HIT_RESET;
    end else if (cfg_we) begin
      no_hit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-3:0], in_valid};
    end
  end

  // Stage 1: differences and registered endpoint coordinates.
  logic signed [DB-1:0] bax, bay, dcx, dcy, acx, acy;
  logic signed [DB-1:0] s_ax0, s_ay0, s_ax1, s_ay1, s_bx0, s_by0, s_bx1, s_by1;
  always_ff @(posedge clk) begin
    if (adv) begin
      bax <= DB'(a_end_x) - DB'(a_start_x);
      bay <= DB'(a_end_y) - DB'(a_start_y);
      dcx <= DB'(b_end_x) - DB'(b_start_x);
      dcy <= DB'(b_end_y) - DB'(b_start_y);
      acx <= DB'(a_start_x) - DB'(b_start_x);
      acy <= DB'(a_start_y) - DB'(b_start_y);
      s_ax0 <= DB'(a_start_x); s_ay0 <= DB'(a_start_y);
      s_ax1 <= DB'(a_end_x);   s_ay1 <= DB'(a_end_y);
      s_bx0 <= DB'(b_start_x); s_by0 <= DB'(b_start_y);
      s_bx1 <= DB'(b_end_x);   s_by1 <= DB'(b_end_y);
    end
  end

  // Stage 2: products. Collinear on-segment tests only need range checks
  // since all three cross products vanish when that branch is used.
  logic signed [PB-1:0] p1, p2, p3, p4, p5, p6, lx, ly;
  logic on_any;
  function automatic logic in_rng(input logic signed [DB-1:0] q,
                                  input logic signed [DB-1:0] e0,
                                  input logic signed [DB-1:0] e1);
    in_rng = ((q >= e0) && (q <= e1)) || ((q >= e1) && (q <= e0));
  endfunction
  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= PB'(bax) * PB'(dcy); p2 <= PB'(bay) * PB'(dcx);
      p3 <= PB'(acy) * PB'(dcx); p4 <= PB'(acx) * PB'(dcy);
      p5 <= PB'(acy) * PB'(bax); p6 <= PB'(acx) * PB'(bay);
      lx <= PB'(bax) * PB'(bax); ly <= PB'(bay) * PB'(bay);
      on_any <=
        (in_rng(s_bx0, s_ax0, s_ax1) && in_rng(s_by0, s_ay0, s_ay1)) ||
        (in_rng(s_bx1, s_ax0, s_ax1) && in_rng(s_by1, s_ay0, s_ay1)) ||
        (in_rng(s_ax0, s_bx0, s_bx1) && in_rng(s_ay0, s_by0, s_by1)) ||
        (in_rng(s_ax1, s_bx0, s_bx1) && in_rng(s_ay1, s_by0, s_by1));
    end
  end

  // Stage 3: cross products and length.
  logic signed [PB:0] den, num, snum;
  logic [PB:0] len2;
  logic on3;
  always_ff @(posedge clk) begin
    if (adv) begin
      den  <= (PB+1)'(p1) - (PB+1)'(p2);
      num  <= (PB+1)'(p3) - (PB+1)'(p4);
      snum <= (PB+1)'(p5) - (PB+1)'(p6);
      len2 <= (PB+1)'(lx) + (PB+1)'(ly);
      on3  <= on_any;
    end
  end

  // Stage 4: sign normalisation and classification.
  logic signed [PB:0] nden, nnum, nsnum;
  logic found4;
  logic meet4;
  logic [PB:0] d4, n4;
  logic [PB:0] len4;
  always_comb begin
    nden  = den[PB] ? -den : den;
    nnum  = den[PB] ? -num : num;
    nsnum = den[PB] ? -snum : snum;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      found4 <= (den != '0) && !nnum[PB] && (nnum <= nden) &&
                !nsnum[PB] && (nsnum <= nden);
      meet4  <= (den == '0) && (num == '0) && (snum == '0) && on3;
      d4     <= nden;
      n4     <= (nnum == nden) ? '0 : nnum;
      len4   <= len2;
    end
  end

  // Division chain; n4 reduced below den, leading quotient bit held apart.
  logic [PB:0] c_rem [NCELL+1];
  logic [PB:0] c_den [NCELL+1];
  logic [Q_BITS-1:0] c_q [NCELL+1];
  logic [PAYW-1:0] c_pay [NCELL+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      c_rem[0] <= n4;
      c_den[0] <= d4;
      c_q[0]   <= '0;
      c_pay[0] <= {found4, meet4, len4};
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      sid_div_cell #(.DW(PB+1), .PW(PAYW)) u_cell (
        .clk(clk), .en(adv),
        .rem_in(c_rem[gi]), .den_in(c_den[gi]), .q_in(c_q[gi]), .pay_in(c_pay[gi]),
        .rem_out(c_rem[gi+1]), .den_out(c_den[gi+1]), .q_out(c_q[gi+1]),
        .pay_out(c_pay[gi+1])
      );
    end
  endgenerate

  // r==1 handling: a sidecar shift line marks items whose num equalled den.
  logic one_src;
  logic [NCELL:0] one_line;
  always_ff @(posedge clk) begin
    if (adv) begin
      one_src <= (nnum == nden);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      one_line <= {one_line[NCELL-1:0], one_src};
    end
  end

  // Multiply stages: t = L*rq >> 32, then d = t*rq >> 32.
  logic [Q_BITS-1:0] rq;
  assign rq = one_line[NCELL] ? (Q_BITS'(1) << 32) : c_q[NCELL];
  logic [PAYW-1:0] pay_m;
  assign pay_m = c_pay[NCELL];

  logic [PB+Q_BITS:0] m1;
  logic [Q_BITS-1:0] rq1;
  logic f1, e1;
  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= (PB+Q_BITS+1)'(pay_m[PB:0]) * (PB+Q_BITS+1)'(rq);
      rq1 <= rq;
      f1  <= pay_m[PB+2];
      e1  <= pay_m[PB+1];
    end
  end
  logic [PB:0] t2;
  logic [Q_BITS-1:0] rq2;
  logic f2, e2;
  always_ff @(posedge clk) begin
    if (adv) begin
      t2  <= m1[PB+32:32];
      rq2 <= rq1;
      f2  <= f1;
      e2  <= e1;
    end
  end
  logic [MW-1:0] m3;
  logic f3, e3;
  always_ff @(posedge clk) begin
    if (adv) begin
      m3 <= MW'(t2) * MW'(rq2);
      f3 <= f2;
      e3 <= e2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[LAT-2];
    end
  end
  logic [MW-33:0] dsh;
  assign dsh = m3[MW-1:32];
  always_ff @(posedge clk) begin
    if (adv) begin
      segments_meet  <= f3 || e3;
      crossing_found <= f3;
      if (!f3) begin
        distance_squared <= no_hit;
      end else if (|dsh[MW-33:DIST_BITS]) begin
        distance_squared <= '1;
      end else begin
        distance_squared <= dsh[DIST_BITS-1:0];
      end
    end
  end

  logic unused_ok;
  assign unused_ok = ^{c_rem[NCELL], c_den[NCELL], m1[31:0], m1[PB+Q_BITS:PB+33], m3[31:0]};

  `ASSERT_IMPL(a_found_meets, clk, rst, out_valid && crossing_found, segments_meet)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_ready, clk, rst, !out_valid, in_ready)
endmodule
`default_nettype wire
